// ===== src/fra_pkg.sv =====
package fra_pkg;
    localparam int unsigned OpW  = 2;
    localparam int unsigned InW  = 16;
    localparam int unsigned NumW = 33;
    localparam int unsigned DenW = 32;
    localparam int unsigned MagW = 32;

    typedef enum logic [OpW-1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE, S_MA, S_MB, S_MD, S_CHK, S_EUC, S_QN, S_QD, S_FIN
    } t_state;

    typedef struct packed {
        logic done;
        logic signed [NumW-1:0] quot;
        logic signed [NumW-1:0] rem;
    } t_div_rsp;
endpackage

// ===== src/fra_if.sv =====
interface fra_in_if;
    logic valid;
    logic ready;
    logic [fra_pkg::OpW-1:0] operation;
    logic signed [fra_pkg::InW-1:0] a_num;
    logic signed [fra_pkg::InW-1:0] a_den;
    logic signed [fra_pkg::InW-1:0] b_num;
    logic signed [fra_pkg::InW-1:0] b_den;
    modport source (output valid, operation, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface

interface fra_out_if;
    logic valid;
    logic ready;
    logic signed [fra_pkg::NumW-1:0] res_num;
    logic signed [fra_pkg::DenW-1:0] res_den;
    logic div_error;
    modport source (output valid, res_num, res_den, div_error, input ready);
    modport sink (input valid, res_num, res_den, div_error, output ready);
endinterface

// ===== src/fraction_arithmetic_reduce.sv =====
// Sequence: the accept state S_IDLE, the multiply states S_MA and S_MD (with S_MB between
//   them for add and subtract), the check state S_CHK, one divider run per Euclid step,
//   the two final divisions S_QN and S_QD, then the output register; a held result stalls S_FIN.
// Items: one at a time, as ready is high only in S_IDLE; a zero denominator skips the Euclid
//   steps and final divisions, otherwise the pace is set by the shared divider.
// Reset: synchronous active low; clears the sequencer, divider and output valid.
module fraction_arithmetic_reduce (
    input  logic i_clk,
    input  logic i_rst_n,
    fra_in_if.sink i_item,
    fra_out_if.source o_res
);
    import fra_pkg::*;

    t_state r_state, n_state;
    t_op r_op;
    logic signed [InW-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [NumW-1:0] r_num, n_num, r_den, n_den;
    logic signed [NumW-1:0] r_n, n_n, r_d, n_d, r_qn, n_qn, r_qd, n_qd;
    logic r_err, n_err, r_go, n_go;
    logic r_ovalid;
    logic signed [NumW-1:0] r_onum;
    logic signed [DenW-1:0] r_oden;
    logic r_oerr;
    logic signed [InW-1:0] mul_a, mul_b;
    logic signed [2*InW-1:0] prod;
    logic signed [NumW-1:0] prod_x;
    logic signed [NumW-1:0] dv_a, dv_b;
    logic load_out;
    t_div_rsp rsp;

    fra_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_go),
        .i_dividend(dv_a),
        .i_divisor (dv_b),
        .o_rsp     (rsp)
    );

    always_comb begin
        mul_a = r_an;
        mul_b = (r_op == OP_MUL) ? r_bn : r_bd;
        unique case (r_state)
            S_MB: begin
                mul_a = r_bn;
                mul_b = r_ad;
            end
            S_MD: begin
                mul_a = r_ad;
                mul_b = (r_op == OP_DIV) ? r_bn : r_bd;
            end
            default: ;
        endcase
    end
    assign prod   = mul_a * mul_b;
    assign prod_x = NumW'(prod);

    always_comb begin
        dv_a = r_n;
        unique case (r_state)
            S_QN: dv_a = r_num;
            S_QD: dv_a = r_den;
            default: ;
        endcase
    end
    assign dv_b = r_d;

    assign load_out = (r_state == S_FIN) && (!r_ovalid || o_res.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_item.valid) n_state = S_MA;
            S_MA:   n_state = (r_op == OP_ADD || r_op == OP_SUB) ? S_MB : S_MD;
            S_MB:   n_state = S_MD;
            S_MD:   n_state = S_CHK;
            S_CHK:  n_state = (r_den == '0) ? S_FIN : S_EUC;
            S_EUC:  if (rsp.done && rsp.rem == '0) n_state = S_QN;
            S_QN:   if (rsp.done) n_state = S_QD;
            S_QD:   if (rsp.done) n_state = S_FIN;
            S_FIN:  if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_num = r_num;
        n_den = r_den;
        n_n   = r_n;
        n_d   = r_d;
        n_qn  = r_qn;
        n_qd  = r_qd;
        n_err = r_err;
        n_go  = 1'b0;
        unique case (r_state)
            S_MA: n_num = prod_x;
            S_MB: n_num = (r_op == OP_SUB) ? r_num - prod_x : r_num + prod_x;
            S_MD: n_den = prod_x;
            S_CHK: begin
                n_err = (r_den == '0);
                n_n   = r_num;
                n_d   = r_den;
                n_go  = (r_den != '0);
            end
            S_EUC: if (rsp.done) begin
                n_go = 1'b1;
                if (rsp.rem != '0) begin
                    n_n = r_d;
                    n_d = rsp.rem;
                end
            end
            S_QN: if (rsp.done) begin
                n_qn = rsp.quot;
                n_go = 1'b1;
            end
            S_QD: if (rsp.done) n_qd = rsp.quot;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_go     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            if (load_out) r_ovalid <= 1'b1;
            else if (o_res.ready) r_ovalid <= 1'b0;
        end
        if (i_item.valid && i_item.ready) begin
            r_op <= t_op'(i_item.operation);
            r_an <= i_item.a_num;
            r_ad <= i_item.a_den;
            r_bn <= i_item.b_num;
            r_bd <= i_item.b_den;
        end
        r_num <= n_num;
        r_den <= n_den;
        r_n   <= n_n;
        r_d   <= n_d;
        r_qn  <= n_qn;
        r_qd  <= n_qd;
        r_err <= n_err;
        if (load_out) begin
            r_oerr <= r_err;
            r_onum <= r_err ? '0 : r_qn;
            r_oden <= r_err ? '0 : r_qd[DenW-1:0];
        end
    end

    assign i_item.ready    = (r_state == S_IDLE);
    assign o_res.valid     = r_ovalid;
    assign o_res.res_num   = r_onum;
    assign o_res.res_den   = r_oden;
    assign o_res.div_error = r_oerr;
endmodule

// ===== src/fra_div.sv =====
module fra_div (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic signed [fra_pkg::NumW-1:0] i_dividend,
    input  logic signed [fra_pkg::NumW-1:0] i_divisor,
    output fra_pkg::t_div_rsp o_rsp
);
    import fra_pkg::*;

    logic r_busy, n_busy;
    logic r_done, n_done;
    logic [4:0] r_cnt, n_cnt;
    logic [MagW-1:0] r_rem, n_rem;
    logic [MagW-1:0] r_quo, n_quo;
    logic [MagW-1:0] r_dvs, n_dvs;
    logic r_qneg, n_qneg, r_rneg, n_rneg;
    logic [NumW-1:0] abs_n, abs_d;
    logic [MagW:0] trial;
    logic signed [NumW-1:0] quo_x, rem_x;

    assign abs_n = i_dividend[NumW-1] ? -i_dividend : i_dividend;
    assign abs_d = i_divisor[NumW-1] ? -i_divisor : i_divisor;
    assign trial = {r_rem, r_quo[MagW-1]} - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_qneg = r_qneg;
        n_rneg = r_rneg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '1;
            n_rem  = '0;
            n_quo  = abs_n[MagW-1:0];
            n_dvs  = abs_d[MagW-1:0];
            n_qneg = i_dividend[NumW-1] ^ i_divisor[NumW-1];
            n_rneg = i_dividend[NumW-1];
        end else if (r_busy) begin
            if (!trial[MagW]) begin
                n_rem = trial[MagW-1:0];
                n_quo = {r_quo[MagW-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[MagW-2:0], r_quo[MagW-1]};
                n_quo = {r_quo[MagW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_dvs  <= n_dvs;
        r_qneg <= n_qneg;
        r_rneg <= n_rneg;
    end

    assign quo_x = {1'b0, r_quo};
    assign rem_x = {1'b0, r_rem};
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_qneg ? -quo_x : quo_x;
    assign o_rsp.rem  = r_rneg ? -rem_x : rem_x;
endmodule

// ===== src/fra_checker.sv =====
module fra_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic signed [fra_pkg::NumW-1:0] i_res_num,
    input logic signed [fra_pkg::DenW-1:0] i_res_den,
    input logic i_div_error
);
    import fra_pkg::*;

    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready right after accept");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_res_num)
        && $stable(i_res_den) && $stable(i_div_error))
        else $error("stalled item changed");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_div_error |-> i_res_num == '0 && i_res_den == '0)
        else $error("error item not zero");
    a_den_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_div_error |-> i_res_den != '0)
        else $error("zero denominator without error");
endmodule

bind fraction_arithmetic_reduce fra_checker u_fra_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_item.valid),
    .i_in_ready (i_item.ready),
    .i_out_valid(o_res.valid),
    .i_out_ready(o_res.ready),
    .i_res_num  (o_res.res_num),
    .i_res_den  (o_res.res_den),
    .i_div_error(o_res.div_error)
);

// ===== dv/fraction_arithmetic_reduce_tb.sv =====
module fraction_arithmetic_reduce_tb;
    import fra_pkg::*;

    typedef struct {
        t_op op;
        logic signed [InW-1:0] a_num;
        logic signed [InW-1:0] a_den;
        logic signed [InW-1:0] b_num;
        logic signed [InW-1:0] b_den;
    } t_frac_item;

    typedef struct {
        logic signed [NumW-1:0] res_num;
        logic signed [DenW-1:0] res_den;
        logic div_error;
    } t_frac_res;

    logic i_clk;
    logic i_rst_n;
    fra_in_if  item_if ();
    fra_out_if res_if ();

    fraction_arithmetic_reduce u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (item_if.sink),
        .o_res  (res_if.source)
    );

    t_frac_item pending_items[$];
    t_frac_res  expected_fracs[$];
    int unsigned send_gap;
    int unsigned recv_gap;
    bit quiet_phase;
    bit failed;
    bit stim_done;
    bit in_taken;
    longint unsigned cycle_cnt;

    function automatic t_frac_res predict_result(t_frac_item it);
        t_frac_res r;
        longint an, ad, bn, bd, num, den, n, d, rm;
        an = it.a_num;
        ad = it.a_den;
        bn = it.b_num;
        bd = it.b_den;
        case (it.op)
            OP_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
            OP_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
            OP_MUL: begin num = an * bn;           den = ad * bd; end
            default: begin num = an * bd;          den = ad * bn; end
        endcase
        if (den == 0) begin
            r.res_num = '0;
            r.res_den = '0;
            r.div_error = 1'b1;
            return r;
        end
        n = num;
        d = den;
        rm = n % d;
        while (rm != 0) begin
            n = d;
            d = rm;
            rm = n % d;
        end
        r.res_num = NumW'(num / d);
        r.res_den = DenW'(den / d);
        r.div_error = 1'b0;
        return r;
    endfunction

    function automatic logic [InW-1:0] pick_field();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4, 5: return InW'($urandom_range(0, 12)) - 16'd6;
            6: return InW'($urandom_range(0, 200)) - 16'd100;
            default: return InW'($urandom);
        endcase
    endfunction

    task automatic queue_item(t_op op, int an, int ad, int bn, int bd);
        t_frac_item it;
        it.op = op;
        it.a_num = InW'(an);
        it.a_den = InW'(ad);
        it.b_num = InW'(bn);
        it.b_den = InW'(bd);
        pending_items.push_back(it);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        t_frac_item it;
        i_rst_n = 1'b0;
        stim_done = 1'b0;
        quiet_phase = 1'b0;
        for (int k = 0; k < 4; k++) begin
            queue_item(t_op'(k), 1, 2, 1, 3);
            queue_item(t_op'(k), -32768, -32768, -32768, -32768);
            queue_item(t_op'(k), 32767, -32768, -32768, 32767);
            queue_item(t_op'(k), 0, 5, 0, 7);
            queue_item(t_op'(k), 3, 0, 4, 5);
        end
        queue_item(OP_DIV, 3, 4, 0, 5);
        queue_item(OP_SUB, 2, 3, 2, 3);
        queue_item(OP_ADD, -1, 2, 1, -2);
        queue_item(OP_MUL, -6, 4, 10, -15);
        queue_item(OP_DIV, 32767, 1, -32768, -1);
        for (int k = 0; k < 550; k++) begin
            it.op = t_op'($urandom_range(0, 3));
            it.a_num = pick_field();
            it.a_den = pick_field();
            it.b_num = pick_field();
            it.b_den = pick_field();
            pending_items.push_back(it);
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (pending_items.size() < 60);
        quiet_phase = 1'b1;
        wait (pending_items.size() == 0);
        stim_done = 1'b1;
    end

    // driver
    initial begin
        item_if.valid = 1'b0;
        item_if.operation = '0;
        item_if.a_num = '0;
        item_if.a_den = '0;
        item_if.b_num = '0;
        item_if.b_den = '0;
        res_if.ready = 1'b0;
        send_gap = 0;
        recv_gap = 0;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_taken) begin
                expected_fracs.push_back(predict_result(pending_items.pop_front()));
                if (!quiet_phase && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 3);
            end
            if (!item_if.valid || in_taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    item_if.valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    item_if.valid <= 1'b1;
                    item_if.operation <= pending_items[0].op;
                    item_if.a_num <= pending_items[0].a_num;
                    item_if.a_den <= pending_items[0].a_den;
                    item_if.b_num <= pending_items[0].b_num;
                    item_if.b_den <= pending_items[0].b_den;
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                res_if.ready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                recv_gap = $urandom_range(0, 2);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_frac_res exp_r;
        in_taken <= i_rst_n && item_if.valid && item_if.ready;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_fracs.size() == 0) begin
                $display("%0t unexpected result num=%0d den=%0d err=%0b", $time,
                         res_if.res_num, res_if.res_den, res_if.div_error);
                failed = 1'b1;
            end else begin
                exp_r = expected_fracs.pop_front();
                if (res_if.res_num !== exp_r.res_num) begin
                    $display("%0t res_num expected %0d actual %0d", $time,
                             exp_r.res_num, res_if.res_num);
                    failed = 1'b1;
                end
                if (res_if.res_den !== exp_r.res_den) begin
                    $display("%0t res_den expected %0d actual %0d", $time,
                             exp_r.res_den, res_if.res_den);
                    failed = 1'b1;
                end
                if (res_if.div_error !== exp_r.div_error) begin
                    $display("%0t div_error expected %0b actual %0b", $time,
                             exp_r.div_error, res_if.div_error);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        failed = 1'b0;
        cycle_cnt = 0;
        fork
            begin
                wait (stim_done && expected_fracs.size() == 0);
                repeat (200) @(posedge i_clk);
                if (!failed && expected_fracs.size() == 0) begin
                    $display("fraction_arithmetic_reduce_tb OK");
                end else begin
                    $display("fraction_arithmetic_reduce_tb NOT OK");
                end
                $finish;
            end
            begin
                while (cycle_cnt < 5000000) begin
                    @(posedge i_clk);
                    cycle_cnt++;
                end
                $display("fraction_arithmetic_reduce_tb NOT OK");
                $finish;
            end
        join
    end
endmodule

// ===== fraction_arithmetic_reduce.f =====
src/fra_pkg.sv
src/fra_if.sv
src/fra_div.sv
src/fraction_arithmetic_reduce.sv
src/fra_checker.sv
dv/fraction_arithmetic_reduce_tb.sv
